[rtl/core/fca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fca_pkg;

	localparam int CAP_W    = 22;
	localparam int RING_W   = 4;
	localparam int BUF_W    = 3;
	localparam int OFFSET_W = 21;
	localparam int DROP_W   = 32;
	localparam int TAIL_W   = 40;
	localparam int CFG_W    = 22;
	localparam int CFG_IDX_W = 2;

	localparam logic [RING_W-1:0] MAX_BUFFERS   = 4'd8;
	localparam logic [CAP_W-1:0]  TRAILER_BYTES = 22'd5;
	localparam logic [31:0]       TRAILER_MARK  = 32'hAA11_CCEE;

	localparam logic [CAP_W-1:0]  CAPTURE_LENGTH_RESET = 22'd1310725;
	localparam logic [RING_W-1:0] BUFFERS_IN_USE_RESET = 4'd8;

	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFERS_IN_USE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED         = 2'd3;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_RETURN = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic             first;
		logic             last;
		logic [CAP_W-1:0] clen;
	} cmd_t;

	typedef struct packed {
		logic                write_enable;
		logic [BUF_W-1:0]    write_buffer;
		logic [OFFSET_W-1:0] write_offset;
		logic [7:0]          write_data;
		logic                frame_done;
		logic [BUF_W-1:0]    done_buffer;
		logic                frame_dropped;
		logic [DROP_W-1:0]   dropped_total;
		logic [RING_W-1:0]   free_buffers;
	} result_t;

	// Effective ring size: zero counts as one, large values clamp to the maximum.
	function automatic logic [RING_W-1:0] ring_size(input logic [RING_W-1:0] n);
		logic [RING_W-1:0] r;
		r = n;
		if (r == '0) begin
			r = 4'd1;
		end
		if (r > MAX_BUFFERS) begin
			r = MAX_BUFFERS;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/fca_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module fca_front
	import fca_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       func,
	input  wire logic [7:0]       data_byte,
	input  wire logic             chunk_first,
	input  wire logic             chunk_last,
	input  wire logic [CAP_W-1:0] chunk_bytes,
	input  wire logic             q_full,
	output logic                  push,
	output cmd_t                  push_cmd
);

	logic  valid_s1;
	cmd_t  cmd_s1;
	cmd_t  cmd_d;
	logic  accept;

	always_comb begin
		cmd_d.data  = data_byte;
		cmd_d.first = chunk_first;
		cmd_d.last  = chunk_last;
		cmd_d.clen  = chunk_bytes;
		cmd_d.kind  = kind_t'(func);
	end

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/fca_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module fca_queue #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/core/fca_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module fca_back
	import fca_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 q_valid,
	input  wire cmd_t                 q_cmd,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output result_t                   res
);

	logic [CAP_W-1:0]  capture_length_q;
	logic [RING_W-1:0] buffers_in_use_q;

	logic [CAP_W-1:0]  received_q;
	logic [RING_W-1:0] fill_q;
	logic [RING_W-1:0] free_q;
	logic [DROP_W-1:0] drop_q;
	logic [TAIL_W-1:0] tail_q;
	logic              chunk_acc_q;
	logic              out_valid_q;
	result_t           res_q;

	logic [CAP_W-1:0]  received_d;
	logic [RING_W-1:0] fill_d;
	logic [RING_W-1:0] free_d;
	logic [DROP_W-1:0] drop_d;
	logic [TAIL_W-1:0] tail_d;
	logic              chunk_acc_d;
	result_t           res_d;

	logic [RING_W-1:0] ring_n;
	logic [CAP_W:0]    fit_sum;
	logic              active;
	logic [CAP_W-1:0]  rc_a;

	assign ring_n    = ring_size(buffers_in_use_q);
	assign pop       = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign fit_sum   = {1'b0, received_q} + {1'b0, q_cmd.clen};

	always_comb begin
		received_d  = received_q;
		fill_d      = fill_q;
		free_d      = free_q;
		drop_d      = drop_q;
		tail_d      = tail_q;
		chunk_acc_d = chunk_acc_q;
		active      = chunk_acc_q;
		rc_a        = received_q;
		res_d       = '0;

		unique case (q_cmd.kind)
			KIND_BYTE: begin
				if (q_cmd.first) begin
					if (free_q != '0 && fit_sum <= {1'b0, capture_length_q}) begin
						chunk_acc_d = 1'b1;
						active      = 1'b1;
					end else begin
						chunk_acc_d         = 1'b0;
						active              = 1'b0;
						drop_d              = drop_q + 1'b1;
						rc_a                = '0;
						res_d.frame_dropped = 1'b1;
					end
				end
				received_d = rc_a;
				if (active) begin
					// Bytes past the capture length or the offset range are not stored.
					if (rc_a < capture_length_q && !rc_a[CAP_W-1]) begin
						res_d.write_enable = 1'b1;
						res_d.write_buffer = fill_q[BUF_W-1:0];
						res_d.write_offset = rc_a[OFFSET_W-1:0];
						res_d.write_data   = q_cmd.data;
						received_d         = rc_a + 1'b1;
						tail_d             = {tail_q[TAIL_W-9:0], q_cmd.data};
					end
					if (q_cmd.last && received_d >= TRAILER_BYTES
							&& tail_d[TAIL_W-1:8] == TRAILER_MARK) begin
						if (received_d == capture_length_q) begin
							res_d.frame_done  = 1'b1;
							res_d.done_buffer = fill_q[BUF_W-1:0];
							if (free_q != '0) begin
								free_d = free_q - 1'b1;
							end
							fill_d     = (fill_q + 1'b1 >= ring_n) ? '0 : fill_q + 1'b1;
							received_d = '0;
						end else if (received_d == TRAILER_BYTES) begin
							// A trailer on its own restarts the frame without a drop.
							received_d = '0;
						end else begin
							drop_d              = drop_d + 1'b1;
							received_d          = '0;
							res_d.frame_dropped = 1'b1;
						end
					end
				end
				if (q_cmd.last) begin
					chunk_acc_d = 1'b0;
				end
			end
			KIND_RETURN: begin
				if (free_q < ring_n) begin
					free_d = free_q + 1'b1;
				end
			end
			KIND_CLEAR: begin
				drop_d = '0;
			end
			KIND_NONE: begin
			end
		endcase

		res_d.dropped_total = drop_d;
		res_d.free_buffers  = free_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_length_q <= CAPTURE_LENGTH_RESET;
			buffers_in_use_q <= BUFFERS_IN_USE_RESET;
			received_q       <= '0;
			fill_q           <= '0;
			free_q           <= ring_size(BUFFERS_IN_USE_RESET);
			drop_q           <= '0;
			tail_q           <= '0;
			chunk_acc_q      <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (pop) begin
				received_q  <= received_d;
				fill_q      <= fill_d;
				free_q      <= free_d;
				drop_q      <= drop_d;
				tail_q      <= tail_d;
				chunk_acc_q <= chunk_acc_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					REG_CAPTURE_LENGTH: capture_length_q <= cfg_data;
					REG_BUFFERS_IN_USE: begin
						buffers_in_use_q <= cfg_data[RING_W-1:0];
						free_q           <= ring_size(cfg_data[RING_W-1:0]);
						fill_q           <= '0;
						received_q       <= '0;
					end
					// The payload size register has no effect on any result.
					REG_FRAME_BYTES: begin
					end
					REG_UNUSED: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/frame_chunk_assembler.sv]
// Frame chunk assembler. Takes one transaction per cycle on the input channel while
// in_stall is low and returns exactly one result transaction per input, in order. An
// input passes a front register that decodes its kind, a small queue, and the back end
// that updates the frame state (byte count, ring position, free buffers, drop counter,
// trailer window) and loads the output register. The sustained rate is one transaction
// per cycle while the output is not stalled. The queue (QUEUE_DEPTH entries) absorbs
// output stalls so the front keeps accepting until the queue is full. Configuration
// writes are taken at once and belong to idle periods.
`timescale 1ns / 1ps
`default_nettype none

module frame_chunk_assembler
	import fca_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           func,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 chunk_first,
	input  wire logic                 chunk_last,
	input  wire logic [CAP_W-1:0]     chunk_bytes,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      write_enable,
	output logic [BUF_W-1:0]          write_buffer,
	output logic [OFFSET_W-1:0]       write_offset,
	output logic [7:0]                write_data,
	output logic                      frame_done,
	output logic [BUF_W-1:0]          done_buffer,
	output logic                      frame_dropped,
	output logic [DROP_W-1:0]         dropped_total,
	output logic [RING_W-1:0]         free_buffers
);

	logic    q_full;
	logic    q_valid;
	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head_cmd;
	result_t res;

	fca_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.data_byte   (data_byte),
		.chunk_first (chunk_first),
		.chunk_last  (chunk_last),
		.chunk_bytes (chunk_bytes),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	fca_queue #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (head_cmd)
	);

	fca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_cmd     (head_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign write_enable  = res.write_enable;
	assign write_buffer  = res.write_buffer;
	assign write_offset  = res.write_offset;
	assign write_data    = res.write_data;
	assign frame_done    = res.frame_done;
	assign done_buffer   = res.done_buffer;
	assign frame_dropped = res.frame_dropped;
	assign dropped_total = res.dropped_total;
	assign free_buffers  = res.free_buffers;

endmodule

`default_nettype wire

[sim/tb_frame_chunk_assembler.sv]
`timescale 1ns / 1ps

module tb_frame_chunk_assembler
	import fca_pkg::*;
();

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 16;
	localparam int unsigned OFFSET_SPAN = 1 << OFFSET_W;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           func;
	logic [7:0]           data_byte;
	logic                 chunk_first;
	logic                 chunk_last;
	logic [CAP_W-1:0]     chunk_bytes;
	logic                 out_valid;
	logic                 out_stall;
	logic                 write_enable;
	logic [BUF_W-1:0]     write_buffer;
	logic [OFFSET_W-1:0]  write_offset;
	logic [7:0]           write_data;
	logic                 frame_done;
	logic [BUF_W-1:0]     done_buffer;
	logic                 frame_dropped;
	logic [DROP_W-1:0]    dropped_total;
	logic [RING_W-1:0]    free_buffers;

	frame_chunk_assembler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.data_byte    (data_byte),
		.chunk_first  (chunk_first),
		.chunk_last   (chunk_last),
		.chunk_bytes  (chunk_bytes),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.write_enable (write_enable),
		.write_buffer (write_buffer),
		.write_offset (write_offset),
		.write_data   (write_data),
		.frame_done   (frame_done),
		.done_buffer  (done_buffer),
		.frame_dropped(frame_dropped),
		.dropped_total(dropped_total),
		.free_buffers (free_buffers)
	);

	// Mirror of the assembler state, updated as each transaction is accepted.
	int unsigned       capture_len;
	logic [RING_W-1:0] ring_reg;
	int unsigned       byte_count;
	int unsigned       fill_slot;
	int unsigned       free_slots;
	logic [DROP_W-1:0] drop_count;
	logic [TAIL_W-1:0] tail_bytes;
	logic              chunk_open;

	result_t    predicted_results[$];
	logic [7:0] frame_image[$];

	int  mismatches;
	int  items_counted;
	int  cycle_count;
	bit  sender_gaps_on;
	bit  receiver_stalls_on;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_frame_chunk_assembler: errors");
			$finish;
		end
	end

	function automatic int unsigned active_ring(input logic [RING_W-1:0] setting);
		if (setting == '0) begin
			return 1;
		end
		return (setting > MAX_BUFFERS) ? MAX_BUFFERS : setting;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
		case (idx)
			REG_CAPTURE_LENGTH: capture_len = value;
			REG_BUFFERS_IN_USE: begin
				ring_reg = value[RING_W-1:0];
				free_slots = active_ring(ring_reg);
				fill_slot = 0;
				byte_count = 0;
			end
			default: ;
		endcase
	endfunction

	function automatic result_t predict_frame_step(input kind_t kind, input logic [7:0] data,
			input logic opens, input logic closes, input logic [CAP_W-1:0] clen);
		result_t     r;
		int unsigned ring;
		logic        active;
		r = '0;
		ring = active_ring(ring_reg);
		case (kind)
			KIND_BYTE: begin
				active = chunk_open;
				if (opens) begin
					if (free_slots != 0 && byte_count + clen <= capture_len) begin
						chunk_open = 1'b1;
						active = 1'b1;
					end else begin
						// A refused chunk discards whatever the frame held so far.
						chunk_open = 1'b0;
						active = 1'b0;
						drop_count++;
						byte_count = 0;
						r.frame_dropped = 1'b1;
					end
				end
				if (active) begin
					if (byte_count < capture_len && byte_count < OFFSET_SPAN) begin
						r.write_enable = 1'b1;
						r.write_buffer = BUF_W'(fill_slot);
						r.write_offset = OFFSET_W'(byte_count);
						r.write_data = data;
						byte_count++;
						tail_bytes = {tail_bytes[TAIL_W-9:0], data};
					end
					if (closes && byte_count >= TRAILER_BYTES
							&& tail_bytes[TAIL_W-1:8] == TRAILER_MARK) begin
						if (byte_count == capture_len) begin
							r.frame_done = 1'b1;
							r.done_buffer = BUF_W'(fill_slot);
							if (free_slots != 0) begin
								free_slots--;
							end
							fill_slot++;
							if (fill_slot >= ring) begin
								fill_slot = 0;
							end
						end else if (byte_count != TRAILER_BYTES) begin
							drop_count++;
							r.frame_dropped = 1'b1;
						end
						byte_count = 0;
					end
				end
				if (closes) begin
					chunk_open = 1'b0;
				end
			end
			KIND_RETURN: begin
				if (free_slots < ring) begin
					free_slots++;
				end
			end
			KIND_CLEAR: drop_count = '0;
			default: ;
		endcase
		r.dropped_total = drop_count;
		r.free_buffers = RING_W'(free_slots);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			return $urandom_range(1, 2);
		end
		if (r < 95) begin
			return $urandom_range(3, 6);
		end
		return $urandom_range(12, 40);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (predicted_results.size() == 0) begin
				$error("result transaction with no expectation pending");
				mismatches++;
			end else begin
				want = predicted_results.pop_front();
				check_field("write_enable", want.write_enable, write_enable);
				check_field("write_buffer", want.write_buffer, write_buffer);
				check_field("write_offset", want.write_offset, write_offset);
				check_field("write_data", want.write_data, write_data);
				check_field("frame_done", want.frame_done, frame_done);
				check_field("done_buffer", want.done_buffer, done_buffer);
				check_field("frame_dropped", want.frame_dropped, frame_dropped);
				check_field("dropped_total", want.dropped_total, dropped_total);
				check_field("free_buffers", want.free_buffers, free_buffers);
			end
		end
	end

	initial begin : result_backpressure
		int stall_left;
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
				if (arst_n && receiver_stalls_on && $urandom_range(0, 99) < 25) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// Called and returns at a falling edge with in_valid low.
	task automatic send_item(input kind_t kind, input logic [7:0] data, input logic opens,
			input logic closes, input logic [CAP_W-1:0] clen);
		int idle;
		bit counts;
		idle = (sender_gaps_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		repeat (idle) @(negedge clk);
		func = kind;
		data_byte = data;
		chunk_first = opens;
		chunk_last = closes;
		chunk_bytes = clen;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		counts = !(kind == KIND_NONE || (kind == KIND_BYTE && !opens && !chunk_open));
		if (counts) begin
			items_counted++;
		end
		predicted_results.push_back(predict_frame_step(kind, data, opens, closes, clen));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_results_drained();
		while (predicted_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		wait_results_drained();
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		apply_register(idx, value);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// Random payload followed by the trailer and one free byte.
	task automatic build_frame(input int payload);
		int i;
		frame_image.delete();
		for (i = 0; i < payload; i++) begin
			frame_image.push_back(8'($urandom));
		end
		frame_image.push_back(TRAILER_MARK[31:24]);
		frame_image.push_back(TRAILER_MARK[23:16]);
		frame_image.push_back(TRAILER_MARK[15:8]);
		frame_image.push_back(TRAILER_MARK[7:0]);
		frame_image.push_back(8'($urandom));
	endtask

	// A non-negative declared length sends the whole image as one chunk with that length.
	task automatic send_image(input int max_chunk, input int declared);
		int pos;
		int len;
		int i;
		logic [CAP_W-1:0] clen;
		pos = 0;
		while (pos < frame_image.size()) begin
			len = (declared >= 0) ? frame_image.size() : $urandom_range(1, max_chunk);
			if (len > frame_image.size() - pos) begin
				len = frame_image.size() - pos;
			end
			for (i = 0; i < len; i++) begin
				if (i == 0) begin
					clen = (declared >= 0) ? CAP_W'(declared) : CAP_W'(len);
				end else begin
					clen = CAP_W'($urandom);
				end
				send_item(KIND_BYTE, frame_image[pos + i], i == 0, i == len - 1, clen);
			end
			pos += len;
		end
	endtask

	task automatic test_command_kinds();
		send_item(KIND_RETURN, 8'h00, 1'b0, 1'b0, '0);
		send_item(KIND_NONE, 8'hff, 1'b1, 1'b1, '1);
		send_item(KIND_BYTE, 8'hff, 1'b0, 1'b1, '1);
		send_item(KIND_BYTE, 8'h00, 1'b1, 1'b0, '1);
		send_item(KIND_CLEAR, 8'h00, 1'b0, 1'b0, '0);
		// A trailer on its own restarts the frame without a drop.
		build_frame(0);
		send_image(0, TRAILER_BYTES);
		// Zero length fits here; a single byte is too short for the trailer check.
		send_item(KIND_BYTE, 8'hff, 1'b1, 1'b1, '0);
	endtask

	task automatic test_config_extremes();
		write_register(REG_CAPTURE_LENGTH, TRAILER_BYTES);
		write_register(REG_FRAME_BYTES, 22'd1);
		write_register(REG_BUFFERS_IN_USE, 22'd1);
		build_frame(0);
		send_image(0, TRAILER_BYTES);
		send_item(KIND_BYTE, 8'h3c, 1'b1, 1'b1, TRAILER_BYTES);
		send_item(KIND_RETURN, 8'h00, 1'b0, 1'b0, '0);
		send_item(KIND_RETURN, 8'h00, 1'b0, 1'b0, '0);
		write_register(REG_CAPTURE_LENGTH, 22'h200000);
		write_register(REG_FRAME_BYTES, 22'h200000);
		write_register(REG_BUFFERS_IN_USE, 22'd0);
		write_register(REG_UNUSED, '1);
		send_item(KIND_BYTE, 8'hff, 1'b1, 1'b0, 22'h200000);
		// A new chunk inside an open one is judged again on its own length.
		send_item(KIND_BYTE, 8'h00, 1'b1, 1'b0, 22'd1);
		send_item(KIND_BYTE, 8'ha5, 1'b1, 1'b1, 22'h200000);
		write_register(REG_BUFFERS_IN_USE, 22'd15);
	endtask

	task automatic test_random_traffic();
		int phase;
		int target;
		int sel;
		int i;
		int unsigned cap;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: cap = TRAILER_BYTES;
				2: cap = $urandom_range(6, 24);
				default: cap = $urandom_range(6, 40);
			endcase
			write_register(REG_CAPTURE_LENGTH, CFG_W'(cap));
			case (phase)
				0: write_register(REG_BUFFERS_IN_USE, 22'd1);
				1: write_register(REG_BUFFERS_IN_USE, 22'd8);
				2: write_register(REG_BUFFERS_IN_USE, 22'd0);
				3: write_register(REG_BUFFERS_IN_USE, 22'd15);
				default: write_register(REG_BUFFERS_IN_USE, CFG_W'($urandom_range(2, 7)));
			endcase
			write_register(REG_FRAME_BYTES, (phase == 1) ? 22'h200000 : CFG_W'($urandom));
			target = items_counted + 280;
			while (items_counted < target) begin
				if ($urandom_range(0, 59) == 0) begin
					sender_gaps_on = 1'($urandom_range(0, 1));
					receiver_stalls_on = 1'($urandom_range(0, 1));
				end
				if ($urandom_range(0, 99) == 0) begin
					wait_results_drained();
				end
				sel = $urandom_range(0, 99);
				if (sel < 62) begin
					if (free_slots == 0 && $urandom_range(0, 9) != 0) begin
						send_item(KIND_RETURN, 8'($urandom), 1'b0, 1'b0, CAP_W'($urandom));
					end
					build_frame(capture_len - TRAILER_BYTES);
					send_image($urandom_range(1, capture_len), -1);
				end else if (sel < 72) begin
					send_item(KIND_RETURN, 8'($urandom), 1'b0, 1'b0, CAP_W'($urandom));
				end else if (sel < 75) begin
					send_item(KIND_CLEAR, 8'($urandom), 1'b0, 1'b0, CAP_W'($urandom));
				end else if (sel < 78) begin
					send_item(KIND_NONE, 8'($urandom), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), CAP_W'($urandom));
				end else if (sel < 83) begin
					build_frame(0);
					send_image(TRAILER_BYTES, -1);
				end else if (sel < 89) begin
					build_frame($urandom_range(0, capture_len - TRAILER_BYTES));
					send_image($urandom_range(1, capture_len), -1);
				end else if (sel < 93) begin
					// Bytes past the capture length are not stored, but the chunk still closes.
					build_frame(capture_len - TRAILER_BYTES);
					for (i = $urandom_range(1, 4); i > 0; i--) begin
						frame_image.push_back(8'($urandom));
					end
					send_image(0, $urandom_range(0, capture_len));
				end else if (sel < 96) begin
					send_item(KIND_BYTE, 8'($urandom), 1'b1, 1'($urandom_range(0, 1)),
						CAP_W'(capture_len - byte_count + $urandom_range(1, 3)));
				end else begin
					for (i = $urandom_range(1, 4); i > 0; i--) begin
						send_item(kind_t'($urandom_range(0, 3)), 8'($urandom),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							CAP_W'($urandom));
					end
				end
			end
		end
	endtask

	initial begin
		capture_len = CAPTURE_LENGTH_RESET;
		ring_reg = BUFFERS_IN_USE_RESET;
		free_slots = active_ring(BUFFERS_IN_USE_RESET);
		byte_count = 0;
		fill_slot = 0;
		drop_count = '0;
		tail_bytes = '0;
		chunk_open = 1'b0;
		mismatches = 0;
		items_counted = 0;
		cycle_count = 0;
		sender_gaps_on = 1'b0;
		receiver_stalls_on = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_CAPTURE_LENGTH;
		cfg_data = '0;
		in_valid = 1'b0;
		func = KIND_BYTE;
		data_byte = '0;
		chunk_first = 1'b0;
		chunk_last = 1'b0;
		chunk_bytes = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		sender_gaps_on = 1'b1;
		receiver_stalls_on = 1'b1;
		test_command_kinds();
		test_config_extremes();
		test_random_traffic();
		wait_results_drained();
		if (mismatches == 0) begin
			$display("tb_frame_chunk_assembler: clean");
		end else begin
			$display("tb_frame_chunk_assembler: errors");
		end
		$finish;
	end

endmodule

[frame_chunk_assembler.f]
rtl/core/fca_pkg.sv
rtl/core/fca_front.sv
rtl/core/fca_queue.sv
rtl/core/fca_back.sv
rtl/core/frame_chunk_assembler.sv
sim/tb_frame_chunk_assembler.sv
